// ----- rtl/booth_signed_multiplier_core_assert.svh -----
// Assertion macros for the Booth multiplier core.
// Used by booth_signed_multiplier_core; no other dependencies.
`ifndef BOOTH_SIGNED_MULTIPLIER_CORE_ASSERT_SVH
`define BOOTH_SIGNED_MULTIPLIER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("booth multiplier check failed");

// Condition that must never hold out of reset.
`define BSM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("booth multiplier illegal condition");

`endif

// ----- rtl/bsm_pkg.sv -----
// Shared types, constants and Booth recoding for the multiplier core.
// No dependencies.
package bsm_pkg;

  localparam int unsigned DefaultWidth = 8;

  typedef enum logic [1:0] {
    BOOTH_NONE,
    BOOTH_ADD,
    BOOTH_SUB
  } booth_op_e;

  // Radix-2 recoding of the bit pair (q[i], q[i-1]).
  function automatic booth_op_e booth_decode(input logic cur, input logic prev);
    booth_op_e op;
    op = BOOTH_NONE;
    if (cur && !prev) op = BOOTH_SUB;
    else if (!cur && prev) op = BOOTH_ADD;
    return op;
  endfunction

endpackage

// ----- rtl/bsm_stage.sv -----
// One Booth iteration as a register stage: add or subtract the shifted multiplicand.
// Depends on bsm_pkg.
module bsm_stage #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned IDX   = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [2*WIDTH-1:0]   acc_i,
  input  logic [WIDTH-1:0]     mcand_i,
  input  logic [WIDTH-1:0]     mplier_i,
  output logic                 valid_o,
  output logic [2*WIDTH-1:0]   acc_o,
  output logic [WIDTH-1:0]     mcand_o,
  output logic [WIDTH-1:0]     mplier_o
);
  import bsm_pkg::*;

  logic               valid_q;
  logic [2*WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0]   mcand_q, mplier_q;
  logic               prev_bit;
  logic [2*WIDTH-1:0] addend;
  booth_op_e          op;

  if (IDX == 0) begin : g_first
    assign prev_bit = 1'b0;
  end else begin : g_rest
    assign prev_bit = mplier_i[IDX-1];
  end

  assign op     = booth_decode(mplier_i[IDX], prev_bit);
  assign addend = {{WIDTH{mcand_i[WIDTH-1]}}, mcand_i} << IDX;

  always_comb begin
    unique case (op)
      BOOTH_ADD: acc_d = acc_i + addend;
      BOOTH_SUB: acc_d = acc_i - addend;
      default:   acc_d = acc_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload needs no reset; valid marks it
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_i;
    mplier_q <= mplier_i;
  end

  assign valid_o  = valid_q;
  assign acc_o    = acc_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;

endmodule

// ----- rtl/booth_signed_multiplier_core.sv -----
// Top level of the radix-2 Booth signed multiplier.
// Depends on bsm_pkg, bsm_stage and booth_signed_multiplier_core_assert.svh.
`include "booth_signed_multiplier_core_assert.svh"
// Usage:
//   Command channel: drive multiplicand_i / multiplier_i and pulse start_i.
//   A word is taken on every rising edge with start_i high and busy_o low.
//   busy_o is always low: a new word may be issued every cycle.
//   Result channel: done_o is high for one cycle with product_o holding the
//   2*WIDTH-bit signed product of a word once it has passed through every stage.
// Structure: one Booth iteration per pipeline stage, one WIDTH*2-bit
//   add/subtract per stage.
// Throughput: one product per cycle; WIDTH words can be in flight.
// Ordering: results come out in issue order; no word is dropped.
// Reset: rst_ni low clears all stage valid bits, so no stale done_o pulses
//   appear; words in flight at reset are discarded.
// The receiver cannot hold results off, so the pipeline never stalls.
module booth_signed_multiplier_core #(
  parameter int unsigned WIDTH = bsm_pkg::DefaultWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [WIDTH-1:0]   multiplicand_i,
  input  logic signed [WIDTH-1:0]   multiplier_i,
  output logic                      done_o,
  output logic signed [2*WIDTH-1:0] product_o
);
  import bsm_pkg::*;

  // Stage k sees the state after k Booth iterations.
  logic                 valid_s  [WIDTH+1];
  logic [2*WIDTH-1:0]   acc_s    [WIDTH+1];
  logic [WIDTH-1:0]     mcand_s  [WIDTH+1];
  logic [WIDTH-1:0]     mplier_s [WIDTH+1];

  // Plain signed product of the operands on the command ports.
  logic signed [2*WIDTH-1:0] exp_product;

  assign busy_o      = 1'b0;
  assign valid_s[0]  = start_i;
  assign acc_s[0]    = '0;
  assign mcand_s[0]  = multiplicand_i;
  assign mplier_s[0] = multiplier_i;

  for (genvar k = 0; k < WIDTH; k++) begin : g_stage
    bsm_stage #(
      .WIDTH (WIDTH),
      .IDX   (k)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_s[k]),
      .acc_i    (acc_s[k]),
      .mcand_i  (mcand_s[k]),
      .mplier_i (mplier_s[k]),
      .valid_o  (valid_s[k+1]),
      .acc_o    (acc_s[k+1]),
      .mcand_o  (mcand_s[k+1]),
      .mplier_o (mplier_s[k+1])
    );
  end

  // Last stage register drives the result ports directly.
  assign done_o    = valid_s[WIDTH];
  assign product_o = acc_s[WIDTH];

  // Both operands sign-extend to 2*WIDTH bits in this context.
  assign exp_product = multiplicand_i * multiplier_i;

  // A result always traces back to a command that passed through every stage.
  `BSM_ASSERT_IMPL(a_done_has_cmd, clk_i, rst_ni, done_o, $past(start_i, WIDTH))

  // The product matches a plain signed multiply of the issued operands.
  `BSM_ASSERT_IMPL(a_product_exact, clk_i, rst_ni, done_o, product_o == $past(exp_product, WIDTH))

endmodule

// ----- verif/tb_booth_signed_multiplier_core.sv -----
// Self-checking testbench for booth_signed_multiplier_core at the default width.
// Depends on bsm_pkg (width, Booth op enum) and the core RTL; it reads no files.
module tb_booth_signed_multiplier_core;
  import bsm_pkg::*;

  localparam int unsigned W             = bsm_pkg::DefaultWidth;
  localparam int unsigned WatchdogLimit = 2000;  // idle cycles before giving up
  localparam int unsigned RandPerPhase  = 234;   // three phases, ~700 words
  localparam int unsigned NumDirected   = 20;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic signed [W-1:0]     multiplicand_i;
  logic signed [W-1:0]     multiplier_i;
  logic                    done_o;
  logic signed [2*W-1:0]   product_o;

  // Products still owed by the core, oldest first.
  logic signed [2*W-1:0]   product_q[$];

  int unsigned err_cnt;
  int unsigned words_sent;
  int unsigned products_checked;
  int unsigned idle_cycles;
  int unsigned sender_idle_pct;

  typedef struct {
    logic signed [W-1:0]   mcand;
    logic signed [W-1:0]   mplier;
    bit                    typed;  // prod below is trusted as written
    logic signed [2*W-1:0] prod;
  } dir_row_t;

  // Directed words: corners of both operands, sign combinations and bit
  // patterns that make every multiplier bit pair recode to add or subtract.
  dir_row_t dir_rows [NumDirected] = '{
    '{0,    0,    1'b1, 0},
    '{127,  127,  1'b1, 16129},
    '{-128, -128, 1'b1, 16384},   // most negative squared, top of range
    '{-128, 127,  1'b1, -16256},
    '{127,  -128, 1'b1, -16256},
    '{-128, 1,    1'b1, -128},
    '{1,    -128, 1'b1, -128},
    '{-1,   -1,   1'b1, 1},
    '{-128, 0,    1'b1, 0},
    '{0,    -128, 1'b1, 0},
    '{-128, -1,   1'b1, 128},
    '{-1,   -128, 1'b1, 128},
    '{1,    1,    1'b1, 1},
    '{-1,   127,  1'b1, -127},
    '{127,  -1,   1'b1, -127},
    '{85,   -86,  1'b0, 0},       // 0x55 x 0xAA: add/sub on every pair but the lowest
    '{-86,  85,   1'b0, 0},
    '{-86,  -86,  1'b0, 0},
    '{64,   -64,  1'b0, 0},
    '{37,   -53,  1'b0, 0}
  };

  booth_signed_multiplier_core #(
    .WIDTH(W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .multiplicand_i (multiplicand_i),
    .multiplier_i   (multiplier_i),
    .done_o         (done_o),
    .product_o      (product_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Radix-2 Booth product, accumulated mod 2^(2W): bit pair (q[i], q[i-1])
  // with q[-1] = 0 picks subtract, add or nothing of mcand << i.
  function automatic logic signed [2*W-1:0] signed_product_of(
      input logic [W-1:0] mcand, input logic [W-1:0] mplier);
    logic [2*W-1:0] mcand_ext;
    logic [2*W-1:0] acc;
    logic           prev;
    booth_op_e      op;
    mcand_ext = {{W{mcand[W-1]}}, mcand};
    acc       = '0;
    prev      = 1'b0;
    for (int i = 0; i < W; i++) begin
      case ({mplier[i], prev})
        2'b10:   op = BOOTH_SUB;
        2'b01:   op = BOOTH_ADD;
        default: op = BOOTH_NONE;
      endcase
      case (op)
        BOOTH_SUB: acc = acc - (mcand_ext << i);
        BOOTH_ADD: acc = acc + (mcand_ext << i);
        default:   acc = acc;
      endcase
      prev = mplier[i];
    end
    return acc;
  endfunction

  // Mostly uniform, with a share of corner values mixed in.
  function automatic logic signed [W-1:0] pick_operand();
    logic signed [W-1:0] corners [6];
    corners = '{-128, -127, -1, 0, 1, 127};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 5)];
    return W'($urandom);
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic signed [2*W-1:0] want,
                                 input logic signed [2*W-1:0] got);
    $display("MISMATCH @%0t %s: expected %0d, got %0d", $time, what, want, got);
    err_cnt++;
  endtask

  // Drive one word at the falling edge after a random gap, hold it until the
  // core takes it, then log what it owes us.
  task automatic send_word(input logic signed [W-1:0] mcand,
                           input logic signed [W-1:0] mplier,
                           input logic signed [2*W-1:0] want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i        <= 1'b0;
      multiplicand_i <= pick_operand();  // noise on the bus while idle
      multiplier_i   <= pick_operand();
      @(negedge clk_i);
    end
    start_i        <= 1'b1;
    multiplicand_i <= mcand;
    multiplier_i   <= mplier;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    product_q.push_back(want);
    words_sent++;
  endtask

  // Result side: done_o marks one product per pulse, in issue order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(done_o)) begin
        report_mismatch("done strobe unknown", '0, '0);
      end else if (done_o) begin
        if (product_q.size() == 0) begin
          report_mismatch("product with no word outstanding", '0, product_o);
        end else begin
          logic signed [2*W-1:0] want;
          want = product_q.pop_front();
          products_checked++;
          if (product_o !== want) report_mismatch("product", want, product_o);
        end
      end
    end
  end

  // Watchdog: any stretch with no word taken and no product out ends the run.
  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: %0d cycles with no progress, %0d products outstanding",
               idle_cycles, product_q.size());
      $display("booth_signed_multiplier_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    int unsigned         phase_pct [3];
    phase_pct        = '{27, 52, 0};
    err_cnt          = 0;
    words_sent       = 0;
    products_checked = 0;
    idle_cycles      = 0;
    sender_idle_pct  = 0;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    multiplicand_i   = '0;
    multiplier_i     = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: back to back, typed rows checked against the table value.
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].mcand, dir_rows[i].mplier,
                dir_rows[i].typed ? dir_rows[i].prod
                                  : signed_product_of(dir_rows[i].mcand,
                                                      dir_rows[i].mplier));
    end

    // Random part: sender gaps at 27%, then 52%, then none.
    foreach (phase_pct[p]) begin
      sender_idle_pct = phase_pct[p];
      repeat (RandPerPhase) begin
        a = pick_operand();
        b = pick_operand();
        send_word(a, b, signed_product_of(a, b));
      end
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // Drain, then keep watching for stray strobes.
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (2 * W) @(posedge clk_i);

    $display("Covered %0d words (%0d directed corners, rest random at 27/52/0%% gaps);",
             words_sent, NumDirected);
    $display("%0d products checked, %0d mismatches.", products_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("booth_signed_multiplier_core verification clean");
    end else begin
      $display("booth_signed_multiplier_core verification failed");
    end
    $finish;
  end

endmodule
